FILE: sv/discovery_packet_filter_dedup_defines.svh
// Assertion macros for the discovery filter RTL.
`ifndef DISCOVERY_PACKET_FILTER_DEDUP_DEFINES_SVH
`define DISCOVERY_PACKET_FILTER_DEDUP_DEFINES_SVH

`ifndef SYNTHESIS
// a in this cycle forces b in the next cycle
`define DPFD_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");
// a forces b in the same cycle
`define DPFD_ASSERT_SAME(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");
`else
`define DPFD_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`define DPFD_ASSERT_SAME(lbl, clk, rst_n, a, b)
`endif

`endif

FILE: sv/dpfd_pkg.sv
// Shared types and constants of the discovery packet filter.
`default_nettype none
package dpfd_pkg;

    localparam int unsigned PACKET_BYTES = 16;
    localparam logic [31:0] MAGIC_RESET  = 32'h4E49_4D44;
    localparam logic [6:0]  CAP_RESET    = 7'd64;

    // result status codes
    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_SELF      = 3'd2;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd3;
    localparam logic [2:0] ST_SHORT     = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    // register indexes
    localparam logic [1:0] REG_SELF_ID  = 2'd0;
    localparam logic [1:0] REG_CAPACITY = 2'd1;
    localparam logic [1:0] REG_MAGIC    = 2'd2;

    // request into the peer table
    typedef struct packed {
        logic        go;     // look up / insert id
        logic        clear;  // empty the table
        logic [31:0] id;
    } t_tbl_req;

    // response from the peer table
    typedef struct packed {
        logic       done;
        logic [2:0] status;
        logic [6:0] total;
    } t_tbl_rsp;

endpackage
`default_nettype wire

FILE: sv/dpfd_peer_table.sv
// Peer id table: memory, linear search and insert.
`default_nettype none
module dpfd_peer_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dpfd_pkg::t_tbl_req i_req,
    input  wire logic [6:0]        i_capacity,
    output dpfd_pkg::t_tbl_rsp     o_rsp,
    output logic                   o_busy
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [8:0] DEPTH9 = 9'(TABLE_DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SRCH = 1'b1;

    logic [31:0] mem [TABLE_DEPTH];

    logic        r_state, n_state;
    logic [6:0]  r_total, n_total;
    logic [6:0]  r_idx, n_idx;
    logic        r_rd_vld;
    logic [31:0] r_id;
    logic [31:0] r_rdata;

    logic w_hit, w_issue, w_miss_done, w_full, w_we;

    assign w_hit       = (r_state == S_SRCH) && r_rd_vld && (r_rdata == r_id);
    assign w_miss_done = (r_state == S_SRCH) && !w_hit && (r_idx == r_total);
    assign w_issue     = (r_state == S_SRCH) && !w_hit && (r_idx != r_total);
    // limit is capacity clamped to the table depth
    assign w_full      = ({2'b00, r_total} >= {2'b00, i_capacity}) ||
                         ({2'b00, r_total} >= DEPTH9);
    assign w_we        = w_miss_done && !w_full;

    always_comb begin
        n_state = r_state;
        n_total = r_total;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_req.clear) begin
                    n_total = '0;
                end else if (i_req.go) begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (w_hit || w_miss_done) begin
                    n_state = S_IDLE;
                end
                if (w_we) begin
                    n_total = r_total + 7'd1;
                end
                if (w_issue) begin
                    n_idx = r_idx + 7'd1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_total  <= '0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_total  <= n_total;
            r_idx    <= n_idx;
            r_rd_vld <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.go) begin
            r_id <= i_req.id;
        end
    end

    // single-port style memory; reads never reach the entry being written
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[AW'(r_total)] <= r_id;
        end
        if (w_issue) begin
            r_rdata <= mem[AW'(r_idx)];
        end
    end

    always_comb begin
        o_rsp.done   = w_hit || w_miss_done;
        o_rsp.total  = w_we ? (r_total + 7'd1) : r_total;
        if (w_hit) begin
            o_rsp.status = dpfd_pkg::ST_DUPLICATE;
        end else if (w_full) begin
            o_rsp.status = dpfd_pkg::ST_FULL;
        end else begin
            o_rsp.status = dpfd_pkg::ST_ADDED;
        end
    end

    assign o_busy = (r_state == S_SRCH);

endmodule
`default_nettype wire

FILE: sv/discovery_packet_filter_dedup.sv
// Discovery datagram filter with peer de-duplication, top level.
//
//  channel   handshake                       payload
//  request   i_start / o_busy                i_mode, i_data_byte, i_last_byte
//  result    o_valid strobe, one cycle       o_status, o_peer_*, o_peers_found
//  config    APB psel/penable/pwrite         paddr, pwdata, prdata
//
// Datagram bytes are taken one per cycle while o_busy is low. A last byte that passes
// length, magic and self checks starts a table walk: one memory read per stored peer
// until a match, with o_busy high meanwhile; the result is registered once it ends.
// Other last bytes give their result on the next cycle without going busy.
// Synchronous active-low reset empties the table count; no clearing pass.
// The result strobe cannot be stalled.
`default_nettype none
`include "discovery_packet_filter_dedup_defines.svh"
module discovery_packet_filter_dedup #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic        i_mode,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    output logic [2:0]       o_status,
    output logic [31:0]      o_peer_dev_id,
    output logic             o_peer_master,
    output logic [15:0]      o_peer_srv_port,
    output logic [15:0]      o_peer_version_major,
    output logic [15:0]      o_peer_version_minor,
    output logic [7:0]       o_peer_role,
    output logic [6:0]       o_peers_found,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [6:0] PKT7 = 7'(dpfd_pkg::PACKET_BYTES);

    logic [31:0] r_self_id;
    logic [6:0]  r_capacity;
    logic [31:0] r_magic;

    logic [6:0]  r_pos, n_pos;
    logic [7:0]  r_hdr [dpfd_pkg::PACKET_BYTES];
    logic [7:0]  n_hdr [dpfd_pkg::PACKET_BYTES];

    logic        r_valid;
    logic [2:0]  r_status;
    logic [31:0] r_dev_id;
    logic        r_master;
    logic [15:0] r_port, r_vmaj, r_vmin;
    logic [7:0]  r_role;
    logic [6:0]  r_found;

    logic        w_acc, w_byte, w_end, w_len_ok, w_magic_ok, w_self, w_go, w_wr;
    logic [31:0] w_magic, w_id;

    dpfd_pkg::t_tbl_req w_req;
    dpfd_pkg::t_tbl_rsp w_rsp;
    logic               w_tbl_busy;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_id  <= '0;
            r_capacity <= dpfd_pkg::CAP_RESET;
            r_magic    <= dpfd_pkg::MAGIC_RESET;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                dpfd_pkg::REG_SELF_ID:  r_self_id  <= pwdata;
                dpfd_pkg::REG_CAPACITY: r_capacity <= pwdata[6:0];
                dpfd_pkg::REG_MAGIC:    r_magic    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            dpfd_pkg::REG_SELF_ID:  prdata = r_self_id;
            dpfd_pkg::REG_CAPACITY: prdata = {25'd0, r_capacity};
            dpfd_pkg::REG_MAGIC:    prdata = r_magic;
            default:                prdata = '0;
        endcase
    end

    // ---------------- byte capture and decode ----------------
    assign w_acc  = i_start && !o_busy;
    assign w_byte = w_acc && !i_mode;
    assign w_end  = w_byte && i_last_byte;

    // header as it stands once this byte is written
    always_comb begin
        for (int k = 0; k < dpfd_pkg::PACKET_BYTES; k++) begin
            n_hdr[k] = r_hdr[k];
        end
        if (r_pos < PKT7) begin
            n_hdr[r_pos[3:0]] = i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_byte && (r_pos < PKT7)) begin
            r_hdr[r_pos[3:0]] <= i_data_byte;
        end
    end

    always_comb begin
        n_pos = r_pos;
        if (w_acc) begin
            if (i_mode || i_last_byte) begin
                n_pos = '0;
            end else if (r_pos != 7'h7F) begin
                n_pos = r_pos + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // length including this byte is r_pos + 1
    assign w_len_ok   = (r_pos >= (PKT7 - 7'd1));
    assign w_magic    = {n_hdr[3], n_hdr[2], n_hdr[1], n_hdr[0]};
    assign w_id       = {n_hdr[4], n_hdr[5], n_hdr[6], n_hdr[7]};
    assign w_magic_ok = (w_magic == r_magic);
    assign w_self     = (w_id == r_self_id);
    assign w_go       = w_end && w_len_ok && w_magic_ok && !w_self;

    assign w_req.go    = w_go;
    assign w_req.clear = w_acc && i_mode;
    assign w_req.id    = w_id;

    dpfd_peer_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_capacity (r_capacity),
        .o_rsp      (w_rsp),
        .o_busy     (w_tbl_busy)
    );

    assign o_busy = w_tbl_busy;

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_rsp.done || (w_end && !w_go);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rsp.done) begin
            r_status <= w_rsp.status;
            r_found  <= w_rsp.total;
        end else if (w_end) begin
            r_found <= w_rsp.total;
            priority if (!w_len_ok) begin
                r_status <= dpfd_pkg::ST_SHORT;
            end else if (!w_magic_ok) begin
                r_status <= dpfd_pkg::ST_BAD_MAGIC;
            end else begin
                r_status <= dpfd_pkg::ST_SELF;
            end
        end
        if (w_end) begin
            if (w_len_ok && w_magic_ok) begin
                r_dev_id <= w_id;
                r_master <= (n_hdr[8] != 8'd0);
                r_port   <= {n_hdr[9], n_hdr[10]};
                r_vmaj   <= {n_hdr[11], n_hdr[12]};
                r_vmin   <= {n_hdr[13], n_hdr[14]};
                r_role   <= n_hdr[15];
            end else begin
                r_dev_id <= '0;
                r_master <= 1'b0;
                r_port   <= '0;
                r_vmaj   <= '0;
                r_vmin   <= '0;
                r_role   <= '0;
            end
        end
    end

    assign o_valid              = r_valid;
    assign o_status             = r_status;
    assign o_peer_dev_id        = r_dev_id;
    assign o_peer_master        = r_master;
    assign o_peer_srv_port      = r_port;
    assign o_peer_version_major = r_vmaj;
    assign o_peer_version_minor = r_vmin;
    assign o_peer_role          = r_role;
    assign o_peers_found        = r_found;

    // ---------------- assertions ----------------
    `DPFD_ASSERT_NEXT(a_go_busy, i_clk, i_rst_n, w_go, o_busy)
    `DPFD_ASSERT_SAME(a_valid_idle, i_clk, i_rst_n, o_valid, !o_busy)
    `DPFD_ASSERT_SAME(a_added_count, i_clk, i_rst_n,
        o_valid && (o_status == dpfd_pkg::ST_ADDED), o_peers_found != 7'd0)

endmodule
`default_nettype wire
